// ===== hw/rtl/k_way_sorted_merge_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the k-way sorted merge block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define KWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Sizes, item and result types, and control structs of the k-way merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int NUM_LISTS  = 8;
	localparam int LIST_DEPTH = 64;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;
	localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PTR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_LISTS * LIST_DEPTH;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_PULL = 1'b1;

	typedef logic [LIST_W-1:0] run_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         list_index;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] merged_value;
		logic                     has_value;
		logic                     overflow;
	} result_t;

	// Sequencer to minimum unit: start a new search, and one head per cycle.
	typedef struct packed {
		logic clear;
		logic valid;
		run_t run;
	} scan_ctl_t;

	// Minimum unit to sequencer: the running winner of the search.
	typedef struct packed {
		logic                     found;
		run_t                     best_run;
		logic signed [DATA_W-1:0] best_val;
	} min_stat_t;

endpackage

// ===== hw/rtl/kwm_ram.sv =====
// ----------------------------------------------------------------------------
// kwm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/kwm_min_unit.sv =====
// ----------------------------------------------------------------------------
// kwm_min_unit
// Shared signed comparator that keeps the smallest head seen in a search.
// ----------------------------------------------------------------------------
module kwm_min_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kwm_pkg::scan_ctl_t               ctl,
	input  logic signed [kwm_pkg::DATA_W-1:0] data,
	output kwm_pkg::min_stat_t               stat
);
	import kwm_pkg::*;

	logic                     found_q;
	run_t                     best_run_q;
	logic signed [DATA_W-1:0] best_val_q;
	logic                     take;

	// Strict less-than keeps the earlier, lower-indexed run on a tie.
	assign take = ctl.valid && (!found_q || (data < best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_run_q <= '0;
			best_val_q <= '0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q    <= 1'b1;
			best_run_q <= ctl.run;
			best_val_q <= data;
		end
	end

	assign stat.found    = found_q;
	assign stat.best_run = best_run_q;
	assign stat.best_val = best_val_q;

endmodule

// ===== hw/rtl/kwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer and run table: push writes, head scan and pull commit.
// ----------------------------------------------------------------------------
`include "k_way_sorted_merge_assert.svh"

module kwm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  kwm_pkg::item_t            item,
	output logic                      done,
	output kwm_pkg::result_t          result,
	output logic                      ram_we,
	output kwm_pkg::addr_t            ram_waddr,
	output logic [kwm_pkg::DATA_W-1:0] ram_wdata,
	output logic                      ram_re,
	output kwm_pkg::addr_t            ram_raddr,
	output kwm_pkg::scan_ctl_t        min_ctl,
	input  kwm_pkg::min_stat_t        min_stat
);
	import kwm_pkg::*;

	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t  state_q;
	item_t   item_q;
	run_t    cur_q;
	ptr_t    rp_q   [NUM_LISTS];
	cnt_t    fill_q [NUM_LISTS];
	logic    rd_valid_s1;
	run_t    rd_run_s1;
	logic    done_q;
	result_t result_q;

	logic             accept;
	run_t             sel_run;
	ptr_t             sel_rp;
	cnt_t             sel_fill;
	logic             push_ok;
	logic [SUM_W-1:0] slot_sum;
	logic [SUM_W-1:0] slot_wrap;
	ptr_t             tail_slot;
	ptr_t             rp_inc;
	addr_t            run_base;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// A single run is looked at per cycle: the pushed run, the scanned run,
	// or the winner while a pull commits.
	assign sel_run  = (state_q == ST_COMMIT) ? min_stat.best_run : cur_q;
	assign sel_rp   = rp_q[sel_run];
	assign sel_fill = fill_q[sel_run];

	assign push_ok = (int'(item_q.list_index) < NUM_LISTS) &&
	                 (sel_fill < CNT_W'(LIST_DEPTH));

	// Tail slot is (head + fill) modulo the depth; the sum stays below twice it.
	assign slot_sum  = SUM_W'(sel_rp) + SUM_W'(sel_fill);
	assign slot_wrap = (slot_sum >= SUM_W'(LIST_DEPTH)) ? slot_sum - SUM_W'(LIST_DEPTH)
	                                                    : slot_sum;
	assign tail_slot = PTR_W'(slot_wrap);
	assign rp_inc    = (sel_rp == PTR_W'(LIST_DEPTH - 1)) ? '0 : sel_rp + ptr_t'(1);
	assign run_base  = ADDR_W'(sel_run) * ADDR_W'(LIST_DEPTH);

	assign ram_we    = (state_q == ST_PUSH) && push_ok;
	assign ram_waddr = run_base + ADDR_W'(tail_slot);
	assign ram_wdata = item_q.value;
	assign ram_re    = (state_q == ST_SCAN);
	assign ram_raddr = run_base + ADDR_W'(sel_rp);

	assign min_ctl.clear = accept;
	assign min_ctl.valid = rd_valid_s1;
	assign min_ctl.run   = rd_run_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			cur_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_run_s1   <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				rp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= (state_q == ST_SCAN) && (sel_fill != '0);
			rd_run_s1   <= cur_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= item;
						if (item.kind == KIND_PULL) begin
							cur_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							cur_q   <= LIST_W'(item.list_index);
							state_q <= ST_PUSH;
						end
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						fill_q[sel_run] <= sel_fill + cnt_t'(1);
					end
					result_q.merged_value <= '0;
					result_q.has_value    <= 1'b0;
					result_q.overflow     <= !push_ok;
					done_q                <= 1'b1;
					state_q               <= ST_IDLE;
				end
				ST_SCAN: begin
					cur_q <= cur_q + run_t'(1);
					if (cur_q == LIST_W'(NUM_LISTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (min_stat.found) begin
						rp_q[sel_run]         <= rp_inc;
						fill_q[sel_run]       <= sel_fill - cnt_t'(1);
						result_q.merged_value <= min_stat.best_val;
						result_q.has_value    <= 1'b1;
					end else begin
						result_q.merged_value <= '0;
						result_q.has_value    <= 1'b0;
					end
					result_q.overflow <= 1'b0;
					done_q            <= 1'b1;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`KWM_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted transfer did not start work")
	`KWM_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy, "result strobe while still busy")
	`KWM_ASSERT_IMP(a_empty_zero, clk, arst_n, done_q && !result_q.has_value, result_q.merged_value == '0, "result without value is not zero")
	`KWM_ASSERT_IMP(a_flags_excl, clk, arst_n, done_q, !(result_q.has_value && result_q.overflow), "value and overflow flagged together")
	`KWM_ASSERT_IMP(a_fill_bound, clk, arst_n, (state_q == ST_PUSH) && (int'(item_q.list_index) < NUM_LISTS), sel_fill <= CNT_W'(LIST_DEPTH), "run fill count above depth")

endmodule

// ===== hw/rtl/k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Push: the push state writes the tail slot and registers the result strobe.
// Pull: a head scan reads one run head per cycle from the single-read-port
// run store, then a drain state covers the last registered read and a commit
// state pops the winner. A new transfer is taken only once the last is done.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset clears every read pointer and fill count; the run store holds no reset.
// ----------------------------------------------------------------------------
module k_way_sorted_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kwm_pkg::item_t   item,
	output logic             done,
	output kwm_pkg::result_t result
);
	import kwm_pkg::*;

	// Every run is a circular FIFO in one region of a shared RAM, addressed by
	// run index times the depth plus the slot. Read pointers and fill counts
	// live in flip-flops in the sequencer, so an empty run's head is never compared.
	logic                     ram_we;
	addr_t                    ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic                     ram_re;
	addr_t                    ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] head_value;

	scan_ctl_t min_ctl;
	min_stat_t min_stat;

	// The sequencer takes one transfer at a time. A push writes the tail slot
	// of its run. A pull walks the runs in index order, one head read per
	// cycle; the registered read data meets the comparator in the next cycle,
	// and the winning run is popped in the commit state.
	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.min_ctl   (min_ctl),
		.min_stat  (min_stat)
	);

	kwm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign head_value = $signed(ram_rdata);

	// One signed comparator serves the whole search. Because runs arrive in
	// ascending index order and only a strictly smaller head replaces the
	// winner, ties resolve to the lowest run index.
	kwm_min_unit u_min (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (min_ctl),
		.data   (head_value),
		.stat   (min_stat)
	);

endmodule
